[design/assert_macros.svh]
// Assertion macros used by the downsampler RTL.
// Depends on nothing; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on the rising edge, disabled while the active-low reset is asserted.
`define ASSERT_AR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Checked on the rising edge at all times.
`define ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_AR(lbl, clk, rstn, prop)
`define ASSERT_NR(lbl, clk, prop)
`endif
`endif

[design/bop_pkg.sv]
// Shared types and constants for the binary OR-pool downsampler.
// No dependencies.
`default_nettype none

package bop_pkg;

  localparam int unsigned IDX_W  = 12;  // width of reduced row/col outputs
  localparam int unsigned CFG_AW = 4;   // APB address width

  localparam logic [1:0] REG_FACTOR = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [7:0]  FACTOR_RST = 8'd20;
  localparam logic [12:0] SIZE_RST   = 13'd4096;

  // Request handed from the position counters to the block accumulator
  typedef struct packed {
    logic             emit;        // last row of block: give out a result
    logic             use_prior;   // not first row of block: merge stored OR
    logic             run;         // OR of this row's pixels within the block
    logic             frame_last;  // final reduced pixel of the image
    logic [IDX_W-1:0] row;         // reduced row index
  } acc_req_t;

endpackage

`default_nettype wire

[design/binary_or_pool_downsampler.sv]
// Binary OR-pool downsampler top level: APB registers and position counters.
// Depends on bop_pkg and bop_block_acc.
//
//   channel  dir  handshake                    payload
//   in       in   in_valid_i / in_stall_o      pixel_value_i
//   out      out  out_valid_o / out_stall_i    occupied_o, reduced_row_o,
//                                              reduced_col_o, frame_last_o
//   cfg      in   psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One pixel per cycle while in_stall_o is low; the result of the pixel that
// closes its block passes the read-modify-write stage (line store read) and
// then the output register before its output transfer.
// Reset clears counters and control; the line store is not cleared, as the
// first row of each row block writes an entry before any row reads it.
// in_stall_o rises only when a result waits in the merge stage behind a
// stalled output register.
`default_nettype none

module binary_or_pool_downsampler #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [7:0]                   pixel_value_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         occupied_o,
  output logic [bop_pkg::IDX_W-1:0]    reduced_row_o,
  output logic [bop_pkg::IDX_W-1:0]    reduced_col_o,
  output logic                         frame_last_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [bop_pkg::CFG_AW-1:0]   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned CLW = $clog2(MAX_WIDTH);
  localparam int unsigned CLH = $clog2(MAX_HEIGHT);
  localparam int unsigned WXW = (CLW + 1 > 13) ? CLW + 1 : 13;
  localparam int unsigned HXW = (CLH + 1 > 13) ? CLH + 1 : 13;
  localparam logic [WXW-1:0] MAXW = WXW'(MAX_WIDTH);
  localparam logic [HXW-1:0] MAXH = HXW'(MAX_HEIGHT);

  // configuration
  logic [7:0]  factor_q;
  logic [12:0] width_q, height_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= bop_pkg::FACTOR_RST;
      width_q  <= bop_pkg::SIZE_RST;
      height_q <= bop_pkg::SIZE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bop_pkg::REG_FACTOR: factor_q <= pwdata[7:0];
        bop_pkg::REG_WIDTH:  width_q  <= pwdata[12:0];
        bop_pkg::REG_HEIGHT: height_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bop_pkg::REG_FACTOR: prdata = 32'(factor_q);
      bop_pkg::REG_WIDTH:  prdata = 32'(width_q);
      bop_pkg::REG_HEIGHT: prdata = 32'(height_q);
      default:             prdata = '0;
    endcase
  end

  // effective limits, as last positions
  logic [7:0]     f_m1;
  logic [WXW-1:0] w_ext, w_m1;
  logic [HXW-1:0] h_ext, h_m1;

  always_comb begin
    f_m1  = (factor_q == 8'd0) ? 8'd0 : factor_q - 8'd1;
    w_ext = WXW'(width_q);
    h_ext = HXW'(height_q);
    if (width_q == 13'd0)  w_m1 = '0;
    else if (w_ext > MAXW) w_m1 = MAXW - WXW'(1);
    else                   w_m1 = w_ext - WXW'(1);
    if (height_q == 13'd0) h_m1 = '0;
    else if (h_ext > MAXH) h_m1 = MAXH - HXW'(1);
    else                   h_m1 = h_ext - HXW'(1);
  end

  // position counters
  logic [CLW-1:0] src_col_q, src_col_d, blk_col_q, blk_col_d;
  logic [CLH-1:0] src_row_q, src_row_d, blk_row_q, blk_row_d;
  logic [7:0]     col_in_blk_q, col_in_blk_d, row_in_blk_q, row_in_blk_d;
  logic           run_or_q, run_or_d;

  logic in_acc, acc_stall;
  logic end_col_block, end_row_block, end_line, end_frame_row;
  logic last_col, run;
  bop_pkg::acc_req_t req;

  assign in_stall_o = acc_stall;
  assign in_acc     = in_valid_i & ~acc_stall;

  always_comb begin
    end_col_block = col_in_blk_q >= f_m1;
    end_row_block = row_in_blk_q >= f_m1;
    end_line      = WXW'(src_col_q) >= w_m1;
    end_frame_row = HXW'(src_row_q) >= h_m1;
    last_col      = end_col_block | end_line;
    run           = ((col_in_blk_q != 8'd0) & run_or_q) | (pixel_value_i != 8'd0);

    req.emit       = end_row_block | end_frame_row;
    req.use_prior  = row_in_blk_q != 8'd0;
    req.run        = run;
    req.frame_last = end_line & end_frame_row;
    req.row        = bop_pkg::IDX_W'(blk_row_q);

    run_or_d     = last_col ? 1'b0 : run;
    src_col_d    = src_col_q + CLW'(1);
    col_in_blk_d = col_in_blk_q + 8'd1;
    blk_col_d    = blk_col_q;
    src_row_d    = src_row_q;
    row_in_blk_d = row_in_blk_q;
    blk_row_d    = blk_row_q;
    if (end_line) begin
      src_col_d    = '0;
      col_in_blk_d = '0;
      blk_col_d    = '0;
      if (end_frame_row) begin
        src_row_d    = '0;
        row_in_blk_d = '0;
        blk_row_d    = '0;
      end else begin
        src_row_d = src_row_q + CLH'(1);
        if (end_row_block) begin
          row_in_blk_d = '0;
          blk_row_d    = blk_row_q + CLH'(1);
        end else begin
          row_in_blk_d = row_in_blk_q + 8'd1;
        end
      end
    end else if (end_col_block) begin
      col_in_blk_d = '0;
      blk_col_d    = blk_col_q + CLW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q    <= '0;
      src_row_q    <= '0;
      col_in_blk_q <= '0;
      row_in_blk_q <= '0;
      blk_col_q    <= '0;
      blk_row_q    <= '0;
      run_or_q     <= 1'b0;
    end else if (in_acc) begin
      src_col_q    <= src_col_d;
      src_row_q    <= src_row_d;
      col_in_blk_q <= col_in_blk_d;
      row_in_blk_q <= row_in_blk_d;
      blk_col_q    <= blk_col_d;
      blk_row_q    <= blk_row_d;
      run_or_q     <= run_or_d;
    end
  end

  bop_block_acc #(
    .DEPTH (MAX_WIDTH)
  ) u_acc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_acc & last_col),
    .req_i         (req),
    .req_addr_i    (blk_col_q),
    .stall_o       (acc_stall),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .occupied_o    (occupied_o),
    .reduced_row_o (reduced_row_o),
    .reduced_col_o (reduced_col_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

`default_nettype wire

[design/bop_block_acc.sv]
// Column-block accumulator: line store memory, read-modify-write stage with
// forwarding, and output register. Depends on bop_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bop_block_acc #(
  parameter int unsigned DEPTH = 4096
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              req_valid_i,
  input  wire  bop_pkg::acc_req_t          req_i,
  input  wire  [$clog2(DEPTH)-1:0]         req_addr_i,
  output logic                             stall_o,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             occupied_o,
  output logic [bop_pkg::IDX_W-1:0]        reduced_row_o,
  output logic [bop_pkg::IDX_W-1:0]        reduced_col_o,
  output logic                             frame_last_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic              line_mem_q [DEPTH];
  logic              rdata_q;

  logic              s1_valid_q, s1_valid_d;
  bop_pkg::acc_req_t s1_req_q;
  logic [AW-1:0]     s1_addr_q;
  logic              fwd_hit_q;
  logic              fwd_data_q;

  logic              out_valid_q, out_valid_d;
  logic              occupied_q;
  logic [bop_pkg::IDX_W-1:0] row_q, col_q;
  logic              frame_last_q;

  logic              acc;
  logic              s1_adv;
  logic              mem_wr;
  logic              rd_en;

  // a write landing at the same edge as a read of that entry is forwarded
  assign acc    = s1_req_q.run |
                  (s1_req_q.use_prior & (fwd_hit_q ? fwd_data_q : rdata_q));
  assign s1_adv = s1_valid_q & (~s1_req_q.emit | ~out_valid_q | ~out_stall_i);
  assign stall_o = s1_valid_q & ~s1_adv;
  assign mem_wr = s1_adv & ~s1_req_q.emit;
  assign rd_en  = req_valid_i & req_i.use_prior;

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      line_mem_q[s1_addr_q] <= acc;
    end
    if (rd_en) begin
      rdata_q <= line_mem_q[req_addr_i];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_valid_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_req_q.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      s1_req_q   <= req_i;
      s1_addr_q  <= req_addr_i;
      fwd_hit_q  <= mem_wr && (s1_addr_q == req_addr_i);
      fwd_data_q <= acc;
    end
    if (s1_adv && s1_req_q.emit) begin
      occupied_q   <= acc;
      row_q        <= s1_req_q.row;
      col_q        <= bop_pkg::IDX_W'(s1_addr_q);
      frame_last_q <= s1_req_q.frame_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign occupied_o    = occupied_q;
  assign reduced_row_o = row_q;
  assign reduced_col_o = col_q;
  assign frame_last_o  = frame_last_q;

  `ASSERT_AR(a_no_req_while_held, clk_i, rst_ni, req_valid_i |-> !stall_o)
  `ASSERT_AR(a_held_stage_stable, clk_i, rst_ni,
             s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_addr_q))
  `ASSERT_AR(a_fwd_on_collision, clk_i, rst_ni,
             mem_wr && rd_en && (s1_addr_q == req_addr_i) |=> fwd_hit_q)

endmodule

`default_nettype wire
